[hdl/fgrt_pkg.sv]
// Shared widths, codes and reset values for the FEC group receive tracker.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package fgrt_pkg;

  localparam int MAX_GROUPS_DEF = 8;

  localparam int DCNT_W = 11;
  localparam int PCNT_W = 10;
  localparam int GCNT_W = 4;
  localparam int IDX_W  = 10;
  localparam int GRP_W  = 3;
  localparam int PEND_W = 4;
  localparam int CNT_W  = 11;
  localparam int DIV_W  = 11;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic OP_RESTART  = 1'b0;
  localparam logic OP_REGISTER = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT  = 2'd2;

  localparam logic [DCNT_W-1:0] DCNT_RST = 11'd1;
  localparam logic [PCNT_W-1:0] PCNT_RST = 10'd0;
  localparam logic [GCNT_W-1:0] GCNT_RST = 4'd1;
  localparam logic [PEND_W-1:0] PEND_RST = 4'd1;

endpackage

[hdl/fec_group_receive_tracker.sv]
// A register beat runs the serial divider by the group count; the divider's done issues the
// counter memory read, an update state then writes the counter back and loads the result,
// and the block returns to idle, where the next beat is accepted; restart and out-of-range
// beats go from idle straight to the update state. A stalled result register holds the update
// state until it drains. One packet is in work at a time, and the result register lets the
// next packet enter while the last result waits.
// Depends on fgrt_pkg, fgrt_div and fgrt_cnt_mem.
module fec_group_receive_tracker #(
  parameter int MAX_GROUPS = fgrt_pkg::MAX_GROUPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fgrt_pkg::IN_TDATA_W-1:0]  in_tdata,   // [9:0] packet_index
  input  logic [0:0]                       in_tuser,   // [0] operation
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [2:0] group_number, [12:3] index_in_group, [13] group_now_complete,
  // [17:14] pending_count, [18] decode_ready, [19] index_error
  output logic [fgrt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fgrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fgrt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int DW = fgrt_pkg::DIV_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [fgrt_pkg::DCNT_W-1:0] dcnt_r;
  logic [fgrt_pkg::PCNT_W-1:0] pcnt_r;
  logic [fgrt_pkg::GCNT_W-1:0] gcnt_r;
  logic [fgrt_pkg::GCNT_W-1:0] ng;

  logic [1:0] state_r, state_nxt;
  logic       op_r, err_r, par_r;
  logic [fgrt_pkg::PEND_W-1:0] pend_r, pend_nxt;

  logic                          in_fire;
  logic [fgrt_pkg::IDX_W-1:0]    idx;
  logic                          idx_err, is_par;
  logic [fgrt_pkg::IDX_W-1:0]    par_off;
  logic [DW-1:0]                 dvd_a;
  logic                          div_start;

  logic                          done_a, done_b;
  logic [DW-1:0]                 q_a, q_b;
  logic [fgrt_pkg::GCNT_W-1:0]   r_a, r_b;

  logic                          rd_en, wr_en, clr;
  logic [GW-1:0]                 grp_addr;
  logic [fgrt_pkg::CNT_W-1:0]    cnt, cnt_inc;
  logic [fgrt_pkg::CNT_W-1:0]    need;
  logic                          sat, hit, commit;

  logic [fgrt_pkg::GRP_W-1:0]    o_grp;
  logic [fgrt_pkg::IDX_W-1:0]    o_sub;
  logic                          o_done, o_err;

  logic                             out_vld_r;
  logic [fgrt_pkg::OUT_TDATA_W-1:0] out_data_r;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= fgrt_pkg::DCNT_RST;
      pcnt_r <= fgrt_pkg::PCNT_RST;
      gcnt_r <= fgrt_pkg::GCNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fgrt_pkg::REG_DATA_COUNT: begin
          dcnt_r <= cfg_data;
        end
        fgrt_pkg::REG_PARITY_COUNT: begin
          pcnt_r <= cfg_data[fgrt_pkg::PCNT_W-1:0];
        end
        fgrt_pkg::REG_GROUP_COUNT: begin
          gcnt_r <= cfg_data[fgrt_pkg::GCNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (gcnt_r == '0) begin
      ng = fgrt_pkg::GCNT_W'(1);
    end else if (int'(gcnt_r) > MAX_GROUPS) begin
      ng = fgrt_pkg::GCNT_W'(MAX_GROUPS);
    end else begin
      ng = gcnt_r;
    end
  end

  // Input beat decode
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign idx       = in_tdata[fgrt_pkg::IDX_W-1:0];
  assign idx_err   = 12'(idx) >= (12'(dcnt_r) + 12'(pcnt_r));
  assign is_par    = 11'(idx) >= dcnt_r;
  assign par_off   = idx - dcnt_r[fgrt_pkg::IDX_W-1:0];
  assign dvd_a     = is_par ? DW'(par_off) : DW'(idx);
  assign div_start = in_fire && (in_tuser[0] == fgrt_pkg::OP_REGISTER) && !idx_err;

  fgrt_div #(.DW(DW)) u_div_idx (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (dvd_a),
    .divisor   (ng),
    .done      (done_a),
    .quotient  (q_a),
    .remainder (r_a)
  );

  fgrt_div #(.DW(DW)) u_div_data (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (DW'(dcnt_r)),
    .divisor   (ng),
    .done      (done_b),
    .quotient  (q_b),
    .remainder (r_b)
  );

  assign grp_addr = GW'(r_a);

  fgrt_cnt_mem #(.DEPTH(MAX_GROUPS), .AW(GW)) u_cnt_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (clr),
    .rd_en   (rd_en),
    .rd_addr (grp_addr),
    .wr_en   (wr_en),
    .wr_addr (grp_addr),
    .wr_data (cnt_inc),
    .rd_data (cnt)
  );

  // Update: group data count is the data quotient, plus one below the data remainder
  assign need    = q_b + fgrt_pkg::CNT_W'(r_a < r_b);
  assign sat     = (cnt == fgrt_pkg::COUNT_MAX);
  assign cnt_inc = cnt + fgrt_pkg::CNT_W'(1);
  assign hit     = !sat && (cnt_inc == need);
  assign commit  = (state_r == S_UPD) && (!out_vld_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    clr       = 1'b0;
    pend_nxt  = pend_r;
    o_grp     = '0;
    o_sub     = '0;
    o_done    = 1'b0;
    o_err     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = div_start ? S_DIV : S_UPD;
        end
      end
      S_DIV: begin
        if (done_a && done_b) begin
          rd_en     = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (op_r == fgrt_pkg::OP_RESTART) begin
          pend_nxt = ng;
          clr      = commit;
        end else if (err_r) begin
          o_err = 1'b1;
        end else begin
          o_grp  = fgrt_pkg::GRP_W'(r_a);
          o_sub  = par_r ? fgrt_pkg::IDX_W'(need + q_a) : fgrt_pkg::IDX_W'(q_a);
          o_done = hit;
          wr_en  = commit && !sat;
          if (hit && (pend_r != '0)) begin
            pend_nxt = pend_r - fgrt_pkg::PEND_W'(1);
          end
        end
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pend_r    <= fgrt_pkg::PEND_RST;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        pend_r    <= pend_nxt;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_tuser[0];
      err_r <= idx_err;
      par_r <= is_par;
    end
    if (commit) begin
      out_data_r <= {4'b0, o_err, (pend_nxt == '0), pend_nxt, o_done, o_sub, o_grp};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

[hdl/fgrt_div.sv]
// Restoring serial divider, one quotient bit per cycle, by a small group-count divisor.
// Depends on fgrt_pkg for the divisor width.
module fgrt_div #(
  parameter int DW = fgrt_pkg::DIV_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DW-1:0]               dividend,
  input  logic [fgrt_pkg::GCNT_W-1:0] divisor,
  output logic                        done,
  output logic [DW-1:0]               quotient,
  output logic [fgrt_pkg::GCNT_W-1:0] remainder
);

  localparam int VW = fgrt_pkg::GCNT_W;
  localparam int SW = $clog2(DW + 1);

  logic [SW-1:0] step_r;
  logic          done_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [VW:0]   shifted;
  logic          ge;

  assign shifted = {rem_r, quo_r[DW-1]};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (step_r == SW'(1));
      if (start) begin
        step_r <= SW'(DW);
      end else if (step_r != '0) begin
        step_r <= step_r - SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (step_r != '0) begin
      quo_r <= {quo_r[DW-2:0], ge};
      rem_r <= ge ? VW'(shifted - {1'b0, dvs_r}) : shifted[VW-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[hdl/fgrt_cnt_mem.sv]
// Per-group received-packet counters: synchronous memory with a registered read.
// Valid bits per entry make a cleared entry read as zero. Depends on fgrt_pkg.
module fgrt_cnt_mem #(
  parameter int DEPTH = fgrt_pkg::MAX_GROUPS_DEF,
  parameter int AW    = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [fgrt_pkg::CNT_W-1:0] wr_data,
  output logic [fgrt_pkg::CNT_W-1:0] rd_data
);

  logic [fgrt_pkg::CNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           vld_r;
  logic [fgrt_pkg::CNT_W-1:0] rd_data_r;
  logic                       rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (clear) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

[hdl/fgrt_checker.sv]
// Port-level checks for fec_group_receive_tracker, attached by the bind at the end.
// Depends on fgrt_pkg for the port widths.
module fgrt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [fgrt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while a packet is in work");

  a_ready_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[18] == (out_tdata[17:14] == 4'd0))
    else $error("decode_ready disagrees with pending_count");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19] |-> out_tdata[13:0] == 14'd0)
    else $error("out-of-range beat carries group fields");

endmodule

bind fec_group_receive_tracker fgrt_checker u_fgrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
